// ===== rtl/gspe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gspe_pkg;

	// shared divider
	localparam int DVD_W     = 41;
	localparam int DVS_W     = 24;
	localparam int DIV_CNT_W = $clog2(DVD_W + 1);

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

	// parameter defaults
	localparam int MEASURE_SAMPLES_DEF   = 10;
	localparam int CALIBRATE_SAMPLES_DEF = 50;
	localparam int ADC_BITS_DEF          = 12;

	// field widths
	localparam int LOAD_W = 16;
	localparam int REF_W  = 24;
	localparam int MV_W   = 12;
	localparam int CONC_W = 14;
	localparam int RS_W   = 25;
	localparam int R_W    = 23;

	// codes
	localparam logic OP_MEASURE   = 1'b0;
	localparam logic OP_CALIBRATE = 1'b1;
	localparam logic REG_LOAD_RES = 1'b0;

	// constants
	localparam logic [11:0]       VREF_MV    = 12'd3300;
	localparam logic [12:0]       SUPPLY_MV  = 13'd5000;
	localparam logic [11:0]       MIN_MV     = 12'd10;
	localparam logic [17:0]       COEF_A     = 18'd255014;
	localparam logic [14:0]       COEF_B     = 15'd30828;
	localparam logic [14:0]       COEF_C     = 15'd27368;
	localparam logic [R_W-1:0]    RATIO_MAX  = 23'h400000;
	localparam logic [CONC_W-1:0] CONC_MAX   = 14'd16000;
	localparam logic [4:0]        CAL_DIV    = 5'd22;
	localparam logic [LOAD_W-1:0] LOAD_RESET = 16'd2560;
	localparam logic [REF_W-1:0]  REF_RESET  = 24'd2560;
	localparam logic [REF_W-1:0]  R24_MAX    = 24'hFFFFFF;

endpackage

`default_nettype wire

// ===== rtl/gspe_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gspe_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire gspe_pkg::div_req_t req,
	output gspe_pkg::div_rsp_t     rsp
);

	logic [gspe_pkg::DVD_W-1:0]     dvd_q;
	logic [gspe_pkg::DVS_W-1:0]     dvs_q;
	logic [gspe_pkg::DVS_W-1:0]     rem_q;
	logic [gspe_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;

	logic [gspe_pkg::DVS_W:0] rem_sh;
	logic [gspe_pkg::DVS_W:0] rem_nx;
	logic                     ge;

	// one restoring step per cycle, quotient bits shift in from the bottom
	always_comb begin
		rem_sh = {rem_q, dvd_q[gspe_pkg::DVD_W-1]};
		ge     = rem_sh >= {1'b0, dvs_q};
		rem_nx = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			dvs_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				dvd_q  <= req.dividend;
				dvs_q  <= req.divisor;
				rem_q  <= '0;
				cnt_q  <= gspe_pkg::DIV_CNT_W'(gspe_pkg::DVD_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				dvd_q <= {dvd_q[gspe_pkg::DVD_W-2:0], ge};
				rem_q <= rem_nx[gspe_pkg::DVS_W-1:0];
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == gspe_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

`default_nettype wire

// ===== rtl/gas_sensor_ppm_estimator_unit.sv =====
// gas sensor ppm estimator
// sample channel: sample_valid / sample_stall carry one word of opcode and
// adc_sample. a word is taken at a clock edge with valid high and stall low.
// words with the same opcode are summed into a run; a change of opcode
// starts a new run with the current word as its first.
// a word that does not complete a run leaves the unit idle for the next word.
// a word that completes a run starts the sequencer, which runs four divisions
// on one shared restoring divider (one quotient bit a cycle) plus multiply
// steps on a registered multiplier. sample_stall stays high meanwhile.
// result channel: result_valid / result_stall carry one word per run from an
// output register. a held word does not block the next run from summing;
// a new result waits in the sequencer until the output register is free.
// apb port: one register, load resistance at addresses 0 to 3 (paddr[2] low), pready always high.
// a zero write is ignored.
// reset: run cleared to measure, load and clean-air resistance at 10 kilohm,
// no result pending.
`timescale 1ns / 1ps
`default_nettype none

module gas_sensor_ppm_estimator_unit #(
	parameter int MEASURE_SAMPLES   = gspe_pkg::MEASURE_SAMPLES_DEF,
	parameter int CALIBRATE_SAMPLES = gspe_pkg::CALIBRATE_SAMPLES_DEF,
	parameter int ADC_BITS          = gspe_pkg::ADC_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,

	input  wire logic        sample_valid,
	output logic             sample_stall,
	input  wire logic        opcode,
	input  wire logic [11:0] adc_sample,

	output logic             result_valid,
	input  wire logic        result_stall,
	output logic             result_kind,
	output logic [13:0]      concentration,
	output logic [23:0]      clean_air_resistance,
	output logic [11:0]      average_millivolts
);

	localparam int MAX_SAMPLES = (MEASURE_SAMPLES > CALIBRATE_SAMPLES) ?
		MEASURE_SAMPLES : CALIBRATE_SAMPLES;
	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W  = ADC_BITS + CNT_W;
	localparam int MULA_W = 29;
	localparam int MULB_W = 23;
	localparam int MULP_W = MULA_W + MULB_W;
	localparam int POS_W  = 48;

	localparam logic [CNT_W-1:0]    MEAS_TGT   = CNT_W'(MEASURE_SAMPLES);
	localparam logic [CNT_W-1:0]    CAL_TGT    = CNT_W'(CALIBRATE_SAMPLES);
	localparam logic [ADC_BITS-1:0] FULL_SCALE = '1;
	localparam logic [11:0]         ADC_MASK   = (ADC_BITS >= 12) ? 12'hFFF :
		12'((1 << ADC_BITS) - 1);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_AVG_GO,
		ST_AVG_W,
		ST_MV_MUL,
		ST_MV_GO,
		ST_MV_W,
		ST_RS_MUL,
		ST_RS_GO,
		ST_RS_W,
		ST_RO_GO,
		ST_RO_W,
		ST_R_GO,
		ST_R_W,
		ST_R2_MUL,
		ST_A_MUL,
		ST_B_MUL,
		ST_CURVE,
		ST_OUT
	} state_t;

	state_t                          state_q;
	logic [SUM_W-1:0]                sum_q;
	logic [CNT_W-1:0]                cnt_q;
	logic                            kind_q;
	logic [gspe_pkg::LOAD_W-1:0]     load_q;
	logic [gspe_pkg::REF_W-1:0]      ref_q;
	logic [ADC_BITS-1:0]             avg_q;
	logic [gspe_pkg::MV_W-1:0]       mv_q;
	logic [gspe_pkg::MV_W-1:0]       mvc_q;
	logic [gspe_pkg::RS_W-1:0]       rs_q;
	logic [gspe_pkg::R_W-1:0]        r_q;
	logic [POS_W-1:0]                pos_q;
	logic [gspe_pkg::CONC_W-1:0]     conc_q;
	logic [MULP_W-1:0]               mul_q;

	logic                            res_valid_q;
	logic                            res_kind_q;
	logic [gspe_pkg::CONC_W-1:0]     res_conc_q;
	logic [gspe_pkg::REF_W-1:0]      res_ref_q;
	logic [gspe_pkg::MV_W-1:0]       res_mv_q;

	gspe_pkg::div_req_t div_req;
	gspe_pkg::div_rsp_t div_rsp;

	logic                            accept;
	logic                            same_run;
	logic [SUM_W-1:0]                sum_nx;
	logic [CNT_W-1:0]                cnt_nx;
	logic [CNT_W-1:0]                tgt_in;
	logic [CNT_W-1:0]                tgt_cur;
	logic [gspe_pkg::RS_W+2:0]       rs5;
	logic [gspe_pkg::REF_W-1:0]      ref_nz;
	logic [gspe_pkg::MV_W-1:0]       mv_nx;
	logic [MULA_W-1:0]               mul_a;
	logic [MULB_W-1:0]               mul_b;
	logic [POS_W-1:0]                neg;
	logic [POS_W-1:0]                diff;
	logic                            cfg_wr;

	gspe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// apb register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == gspe_pkg::REG_LOAD_RES) ? {16'b0, load_q} : '0;

	// run bookkeeping
	assign accept   = sample_valid && !sample_stall;
	assign same_run = (opcode == kind_q);
	assign sum_nx   = (same_run ? sum_q : '0) + SUM_W'(adc_sample & ADC_MASK);
	assign cnt_nx   = (same_run ? cnt_q : '0) + 1'b1;
	assign tgt_in   = (opcode == gspe_pkg::OP_CALIBRATE) ? CAL_TGT : MEAS_TGT;
	assign tgt_cur  = (kind_q == gspe_pkg::OP_CALIBRATE) ? CAL_TGT : MEAS_TGT;

	assign rs5    = {1'b0, rs_q, 2'b00} + (gspe_pkg::RS_W+3)'(rs_q);
	assign ref_nz = (ref_q == '0) ? gspe_pkg::REF_W'(1) : ref_q;
	assign mv_nx  = (div_rsp.quotient > gspe_pkg::DVD_W'(gspe_pkg::VREF_MV)) ?
		gspe_pkg::VREF_MV : div_rsp.quotient[gspe_pkg::MV_W-1:0];
	assign neg    = mul_q[POS_W-1:0];
	assign diff   = pos_q - neg;

	// divider operands
	always_comb begin
		div_req = '0;
		case (state_q)
			ST_AVG_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = gspe_pkg::DVD_W'(sum_q);
				div_req.divisor  = gspe_pkg::DVS_W'(tgt_cur);
			end
			ST_MV_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = gspe_pkg::DVD_W'(mul_q);
				div_req.divisor  = gspe_pkg::DVS_W'(FULL_SCALE);
			end
			ST_RS_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = gspe_pkg::DVD_W'(mul_q);
				div_req.divisor  = gspe_pkg::DVS_W'(mvc_q);
			end
			ST_RO_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = gspe_pkg::DVD_W'(rs5);
				div_req.divisor  = gspe_pkg::DVS_W'(gspe_pkg::CAL_DIV);
			end
			ST_R_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = gspe_pkg::DVD_W'({rs_q, 16'b0});
				div_req.divisor  = ref_nz;
			end
			default: begin
				div_req = '0;
			end
		endcase
	end

	// multiplier operands
	always_comb begin
		case (state_q)
			ST_MV_MUL: begin
				mul_a = MULA_W'(avg_q);
				mul_b = MULB_W'(gspe_pkg::VREF_MV);
			end
			ST_RS_MUL: begin
				mul_a = MULA_W'(gspe_pkg::SUPPLY_MV - 13'(mvc_q));
				mul_b = MULB_W'(load_q);
			end
			ST_R2_MUL: begin
				mul_a = MULA_W'(r_q);
				mul_b = r_q;
			end
			ST_A_MUL: begin
				mul_a = mul_q[44:16];
				mul_b = MULB_W'(gspe_pkg::COEF_A);
			end
			ST_B_MUL: begin
				mul_a = MULA_W'(r_q);
				mul_b = MULB_W'(gspe_pkg::COEF_B);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= MULP_W'(mul_a) * MULP_W'(mul_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			cnt_q       <= '0;
			kind_q      <= gspe_pkg::OP_MEASURE;
			load_q      <= gspe_pkg::LOAD_RESET;
			ref_q       <= gspe_pkg::REF_RESET;
			avg_q       <= '0;
			mv_q        <= '0;
			mvc_q       <= '0;
			rs_q        <= '0;
			r_q         <= '0;
			pos_q       <= '0;
			conc_q      <= '0;
			res_valid_q <= 1'b0;
			res_kind_q  <= 1'b0;
			res_conc_q  <= '0;
			res_ref_q   <= '0;
			res_mv_q    <= '0;
		end else begin
			if (cfg_wr && paddr[2] == gspe_pkg::REG_LOAD_RES && pwdata[15:0] != '0) begin
				load_q <= pwdata[15:0];
			end
			if (res_valid_q && !result_stall && state_q != ST_OUT) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						kind_q <= opcode;
						sum_q  <= sum_nx;
						if (cnt_nx == tgt_in) begin
							cnt_q   <= '0;
							state_q <= ST_AVG_GO;
						end else begin
							cnt_q <= cnt_nx;
						end
					end
				end
				ST_AVG_GO: begin
					sum_q   <= '0;
					state_q <= ST_AVG_W;
				end
				ST_AVG_W: begin
					if (div_rsp.done) begin
						avg_q   <= div_rsp.quotient[ADC_BITS-1:0];
						state_q <= ST_MV_MUL;
					end
				end
				ST_MV_MUL: begin
					state_q <= ST_MV_GO;
				end
				ST_MV_GO: begin
					state_q <= ST_MV_W;
				end
				ST_MV_W: begin
					if (div_rsp.done) begin
						mv_q    <= mv_nx;
						mvc_q   <= (mv_nx < gspe_pkg::MIN_MV) ? gspe_pkg::MIN_MV : mv_nx;
						state_q <= ST_RS_MUL;
					end
				end
				ST_RS_MUL: begin
					state_q <= ST_RS_GO;
				end
				ST_RS_GO: begin
					state_q <= ST_RS_W;
				end
				ST_RS_W: begin
					if (div_rsp.done) begin
						rs_q    <= div_rsp.quotient[gspe_pkg::RS_W-1:0];
						state_q <= (kind_q == gspe_pkg::OP_CALIBRATE) ? ST_RO_GO : ST_R_GO;
					end
				end
				ST_RO_GO: begin
					state_q <= ST_RO_W;
				end
				ST_RO_W: begin
					if (div_rsp.done) begin
						ref_q <= (div_rsp.quotient > gspe_pkg::DVD_W'(gspe_pkg::R24_MAX)) ?
							gspe_pkg::R24_MAX : div_rsp.quotient[gspe_pkg::REF_W-1:0];
						conc_q  <= '0;
						state_q <= ST_OUT;
					end
				end
				ST_R_GO: begin
					state_q <= ST_R_W;
				end
				ST_R_W: begin
					if (div_rsp.done) begin
						r_q <= (div_rsp.quotient > gspe_pkg::DVD_W'(gspe_pkg::RATIO_MAX)) ?
							gspe_pkg::RATIO_MAX : div_rsp.quotient[gspe_pkg::R_W-1:0];
						state_q <= ST_R2_MUL;
					end
				end
				ST_R2_MUL: begin
					state_q <= ST_A_MUL;
				end
				ST_A_MUL: begin
					state_q <= ST_B_MUL;
				end
				ST_B_MUL: begin
					pos_q   <= mul_q[POS_W-1:0] + (POS_W'(gspe_pkg::COEF_C) << 16);
					state_q <= ST_CURVE;
				end
				ST_CURVE: begin
					if (pos_q <= neg) begin
						conc_q <= '0;
					end else if (diff[47:28] > 20'(gspe_pkg::CONC_MAX)) begin
						conc_q <= gspe_pkg::CONC_MAX;
					end else begin
						conc_q <= diff[41:28];
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!res_valid_q || !result_stall) begin
						res_valid_q <= 1'b1;
						res_kind_q  <= kind_q;
						res_conc_q  <= conc_q;
						res_ref_q   <= ref_q;
						res_mv_q    <= mv_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign sample_stall         = (state_q != ST_IDLE);
	assign result_valid         = res_valid_q;
	assign result_kind          = res_kind_q;
	assign concentration        = res_conc_q;
	assign clean_air_resistance = res_ref_q;
	assign average_millivolts   = res_mv_q;

	// checks
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_count_below_target: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < tgt_cur)
		else $error("run count reached target without completing");

	a_result_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result word not loaded by the sequencer");

	a_cal_conc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_kind_q == gspe_pkg::OP_CALIBRATE) |-> (res_conc_q == '0))
		else $error("calibration word carries a concentration");

	a_conc_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_conc_q <= gspe_pkg::CONC_MAX))
		else $error("concentration above clamp");

endmodule

`default_nettype wire
